// File: design/simon_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the round function for the Simon128 encryption block.
// Used by the channel interfaces and by simon128_block_encrypt; depends on nothing.
package simon_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned KEY_IDX_W   = 7;
  localparam int unsigned ROUNDS_DEF  = 68;

  localparam int unsigned ROT_AND_A   = 1;
  localparam int unsigned ROT_AND_B   = 8;
  localparam int unsigned ROT_XOR     = 2;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_ENCRYPT = 1'b1
  } mode_e;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  // Simon round function: (x <<< 1 & x <<< 8) ^ x <<< 2.
  function automatic word_t simon_f(input word_t v);
    simon_f = (rotl(v, ROT_AND_A) & rotl(v, ROT_AND_B)) ^ rotl(v, ROT_XOR);
  endfunction

endpackage

// File: design/simon_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the Simon128 encryption block.
// Depends on simon_pkg for the payload widths.
interface simon_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  simon_pkg::key_idx_t        key_index;
  simon_pkg::word_t           key_word;
  simon_pkg::word_t           block_low;
  simon_pkg::word_t           block_high;

  modport source (output valid, mode, key_index, key_word, block_low, block_high,
                  input ready);
  modport sink   (input valid, mode, key_index, key_word, block_low, block_high,
                  output ready);
endinterface

interface simon_out_if;
  logic                       valid;
  logic                       ready;
  simon_pkg::word_t           cipher_low;
  simon_pkg::word_t           cipher_high;

  modport source (output valid, cipher_low, cipher_high, input ready);
  modport sink   (input valid, cipher_low, cipher_high, output ready);
endinterface

// File: design/simon128_block_encrypt.sv
`timescale 1ns / 1ps
// Simon128 encryption over a store of pre-expanded round keys.
// Depends on simon_pkg and on the channel interfaces in simon_if.sv.
//
// Usage:
//   in_i carries one beat per item. mode = load writes key_word into round key
//   slot key_index (slots at or beyond ROUND_COUNT are ignored) and gives no
//   result. mode = encrypt runs ROUND_COUNT Simon rounds on {block_high,
//   block_low} and gives one beat on out_o with the ciphertext.
//   The round keys sit in two memories with registered reads, even rounds in
//   one and odd rounds in the other, so one key pair is read per cycle and
//   two rounds are computed per cycle while an encryption runs.
//   A load is written on its accepting edge and the block stays idle. An
//   encrypt reads the first key pair as it is accepted, then runs the round
//   pairs in order up to the last, whose result goes to the output register,
//   or waits in the hold state while that register is still full.
//   in_i.ready is high only while no encryption is in progress. The output
//   register lets a new item be accepted while a result still waits; if the
//   receiver stalls when a further result is ready, the block holds it and
//   accepts nothing until the output register frees.
//   Reset clears the state, data and output registers but not the key memories; round keys must be loaded before use.
//   A load and an encrypt never share a cycle, so a key written by one beat is
//   always visible to an encrypt accepted in the next.
module simon128_block_encrypt #(
  parameter int unsigned ROUND_COUNT = simon_pkg::ROUNDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  simon_in_if.sink           in_i,
  simon_out_if.source        out_o
);

  localparam int unsigned PAIRS  = (ROUND_COUNT + 1) / 2;
  localparam int unsigned PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);
  localparam logic [simon_pkg::KEY_IDX_W-1:0] KEY_LIMIT =
    simon_pkg::KEY_IDX_W'(ROUND_COUNT);
  localparam bit ODD_ROUNDS = (ROUND_COUNT % 2) == 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e                state_q, state_d;
  logic [PAIR_W-1:0]     pair_q, pair_d;
  simon_pkg::word_t      x_q, x_d, y_q, y_d;
  logic                  out_valid_q, out_valid_d;
  simon_pkg::word_t      c_low_q, c_low_d, c_high_q, c_high_d;

  simon_pkg::word_t      key_even_mem [PAIRS];
  simon_pkg::word_t      key_odd_mem  [PAIRS];
  simon_pkg::word_t      key_even_q, key_odd_q;

  logic                  in_fire, enc_start, key_wr, wr_odd;
  logic [PAIR_W-1:0]     wr_addr, rd_addr;
  logic                  rd_en, last_pair, out_free;
  simon_pkg::word_t      y_rnd, x_rnd, x_fin;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign enc_start  = in_fire && (in_i.mode == simon_pkg::MODE_ENCRYPT);
  assign key_wr     = in_fire && (in_i.mode == simon_pkg::MODE_LOAD) &&
                      (in_i.key_index < KEY_LIMIT);
  assign wr_odd     = in_i.key_index[0];
  assign wr_addr    = in_i.key_index[PAIR_W:1];

  assign last_pair  = (pair_q == LAST_PAIR);
  assign out_free   = !out_valid_q || out_o.ready;

  // Read the first pair on the accepting edge, then one pair ahead each cycle.
  assign rd_en   = enc_start || ((state_q == ST_RUN) && !last_pair);
  assign rd_addr = enc_start ? '0 : pair_q + PAIR_W'(1);

  always_ff @(posedge clk_i) begin
    if (key_wr && !wr_odd) begin
      key_even_mem[wr_addr] <= in_i.key_word;
    end
    if (rd_en) begin
      key_even_q <= key_even_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr && wr_odd) begin
      key_odd_mem[wr_addr] <= in_i.key_word;
    end
    if (rd_en) begin
      key_odd_q <= key_odd_mem[rd_addr];
    end
  end

  // Two rounds: the even one updates y, the odd one updates x. With an odd
  // round count the final pair holds only its even round.
  assign y_rnd = y_q ^ simon_pkg::simon_f(x_q) ^ key_even_q;
  assign x_rnd = x_q ^ simon_pkg::simon_f(y_rnd) ^ key_odd_q;
  assign x_fin = (ODD_ROUNDS && last_pair) ? x_q : x_rnd;

  always_comb begin
    state_d     = state_q;
    pair_d      = pair_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q;
    c_low_d     = c_low_q;
    c_high_d    = c_high_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (enc_start) begin
          state_d = ST_RUN;
          pair_d  = '0;
          x_d     = in_i.block_high;
          y_d     = in_i.block_low;
        end
      end
      ST_RUN: begin
        y_d = y_rnd;
        x_d = x_fin;
        if (last_pair) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            c_low_d     = y_rnd;
            c_high_d    = x_fin;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end else begin
          pair_d = pair_q + PAIR_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          c_low_d     = y_q;
          c_high_d    = x_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pair_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
      c_low_q     <= '0;
      c_high_q    <= '0;
    end else begin
      state_q     <= state_d;
      pair_q      <= pair_d;
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
      c_low_q     <= c_low_d;
      c_high_q    <= c_high_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cipher_low  = c_low_q;
  assign out_o.cipher_high = c_high_q;

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_start |=> (state_q == ST_RUN) && (pair_q == '0))
    else $error("encrypt beat did not start the round sequence at pair zero");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.mode == simon_pkg::MODE_LOAD)) |=> (state_q == ST_IDLE))
    else $error("key load left the idle state");

  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pair_q <= LAST_PAIR))
    else $error("round pair counter ran past the last pair");

  a_busy_to_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && last_pair && out_valid_q && !out_o.ready)
      |=> (state_q == ST_HOLD) && out_valid_q)
    else $error("finished result did not wait for a busy output register");

  a_no_read_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && last_pair) |-> !rd_en)
    else $error("key read issued after the last round pair");

endmodule
